@@ src/weighted_bilinear_image_shift_defines.svh @@
// ----------------------------------------------------------------------------
// weighted bilinear image shift: assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_BILINEAR_IMAGE_SHIFT_DEFINES_SVH
`define WEIGHTED_BILINEAR_IMAGE_SHIFT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define WBIS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define WBIS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/wbis_pkg.sv @@
// ----------------------------------------------------------------------------
// wbis_pkg
// types and constants of the weighted bilinear image shift
// ----------------------------------------------------------------------------
package wbis_pkg;

    localparam int unsigned ONE_Q16     = 65536;
    localparam int unsigned MAX_HEIGHT  = 4096;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned NUM_W       = 60;   // numerator accumulator
    localparam int unsigned MAG_W       = 58;   // numerator magnitude / quotient

    // configuration register indexes
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_FRAC_X       = 3'd2;
    localparam logic [2:0] REG_FRAC_Y       = 3'd3;
    localparam logic [2:0] REG_OFFSET_X     = 3'd4;
    localparam logic [2:0] REG_OFFSET_Y     = 3'd5;

    typedef struct packed {
        logic signed [31:0] pixel_value;
        logic signed [23:0] pixel_weight;
        logic               start_of_frame;
    } wbis_in_t;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic signed [23:0] out_weight;
        logic        [12:0] out_col;
        logic        [12:0] out_row;
        logic               last_of_frame;
    } wbis_out_t;

    // one neighbourhood: 0 upper-left, 1 upper-right, 2 lower-left, 3 lower-right
    typedef struct packed {
        logic [3:0][23:0] wt;
        logic [3:0][31:0] val;
        logic      [12:0] col;
        logic      [12:0] row;
        logic             last;
    } wbis_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } wbis_qstat_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_READ,
        F_PUSH
    } wbis_front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_AREA,
        B_WV,
        B_AW,
        B_ATL,
        B_ATH,
        B_FIN,
        B_DIV,
        B_OUT
    } wbis_back_state_t;

endpackage

@@ src/wbis_front.sv @@
// ----------------------------------------------------------------------------
// wbis_front
// takes pixels, keeps the row store and neighbours, forms neighbourhood jobs
// ----------------------------------------------------------------------------
module wbis_front import wbis_pkg::*; #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  wbis_in_t    s_payload,
    input  logic [12:0] image_width,
    input  logic [12:0] image_height,
    input  logic [10:0] offset_x,
    input  logic [10:0] offset_y,
    input  wbis_qstat_t q_stat,
    output logic        q_push,
    output wbis_job_t   q_data
);

    localparam int AW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;

    wbis_front_state_t state_reg, state_next;

    logic [AW-1:0] col_reg, col_next, at_col_reg;
    logic [11:0]   row_reg, row_next, at_row_reg;
    logic [AW-1:0] cur_col;
    logic [11:0]   cur_row;
    logic [15:0]   wd_full, wd_m1;
    logic [12:0]   ht_full;
    logic [11:0]   ht_m1;
    logic          accept, emit, done;

    logic [55:0] mem [MAX_WIDTH];
    logic [55:0] up_reg, upl_reg, left_reg, pix_reg;
    logic [31:0] col_sum, row_sum;

    // size clamping
    always_comb begin
        if (image_width < 13'd2) begin
            wd_full = 16'd2;
        end else if (32'(image_width) > MAX_WIDTH) begin
            wd_full = 16'(MAX_WIDTH);
        end else begin
            wd_full = 16'(image_width);
        end
        if (image_height < 13'd2) begin
            ht_full = 13'd2;
        end else if (32'(image_height) > MAX_HEIGHT) begin
            ht_full = 13'(MAX_HEIGHT);
        end else begin
            ht_full = image_height;
        end
        wd_m1 = wd_full - 16'd1;
        ht_m1 = 12'(ht_full - 13'd1);
    end

    assign accept  = s_valid && s_ready;
    assign cur_col = s_payload.start_of_frame ? '0 : col_reg;
    assign cur_row = s_payload.start_of_frame ? '0 : row_reg;
    assign emit    = (at_row_reg != '0) && (at_col_reg != '0);
    assign done    = !emit || !q_stat.full;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (16'(cur_col) >= wd_m1) begin
                col_next = '0;
                row_next = (cur_row >= ht_m1) ? '0 : cur_row + 12'd1;
            end else begin
                col_next = cur_col + AW'(1);
                row_next = cur_row;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:  if (accept) state_next = F_READ;
            F_READ:  state_next = F_PUSH;
            F_PUSH:  if (done) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready = 1'b0;
        q_push  = 1'b0;
        case (state_reg)
            F_IDLE:  s_ready = 1'b1;
            F_PUSH:  q_push  = emit && !q_stat.full;
            default: ;
        endcase
    end

    assign col_sum = 32'(at_col_reg) - 32'd1 + 32'(offset_x);
    assign row_sum = 32'(at_row_reg) - 32'd1 + 32'(offset_y);

    always_comb begin
        q_data.wt[0]  = upl_reg[23:0];
        q_data.val[0] = upl_reg[55:24];
        q_data.wt[1]  = up_reg[23:0];
        q_data.val[1] = up_reg[55:24];
        q_data.wt[2]  = left_reg[23:0];
        q_data.val[2] = left_reg[55:24];
        q_data.wt[3]  = pix_reg[23:0];
        q_data.val[3] = pix_reg[55:24];
        q_data.col    = col_sum[12:0];
        q_data.row    = row_sum[12:0];
        q_data.last   = (at_row_reg >= ht_m1) && (16'(at_col_reg) >= wd_m1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            upl_reg   <= '0;
            left_reg  <= '0;
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            if (state_reg == F_PUSH && done) begin
                upl_reg  <= up_reg;
                left_reg <= pix_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg    <= {s_payload.pixel_value, s_payload.pixel_weight};
            at_col_reg <= cur_col;
            at_row_reg <= cur_row;
        end
    end

    // row store: old entry read out as the new pixel goes in
    always_ff @(posedge aclk) begin
        if (state_reg == F_READ) begin
            up_reg          <= mem[at_col_reg];
            mem[at_col_reg] <= pix_reg;
        end
    end

endmodule

@@ src/wbis_queue.sv @@
// ----------------------------------------------------------------------------
// wbis_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module wbis_queue import wbis_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  wbis_job_t   push_data,
    input  logic        pop,
    output wbis_job_t   head,
    output wbis_qstat_t stat
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    wbis_job_t       slot [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]     count_reg;

    assign stat.full  = (count_reg == (PW + 1)'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = slot[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + PW'(1);
            if (push && !pop) begin
                count_reg <= count_reg + (PW + 1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (PW + 1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) slot[wr_ptr_reg] <= push_data;
    end

endmodule

@@ src/wbis_back.sv @@
// ----------------------------------------------------------------------------
// wbis_back
// area weighting on one shared multiplier, then, for a positive weight, a bit-serial divide
// ----------------------------------------------------------------------------
module wbis_back import wbis_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [16:0] frac_x,
    input  logic [16:0] frac_y,
    input  wbis_job_t   head,
    input  wbis_qstat_t q_stat,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output wbis_out_t   m_payload
);

    wbis_back_state_t state_reg, state_next;

    wbis_job_t                 job_reg;
    logic        [1:0]         k_reg;
    logic                      half_reg;
    logic        [16:0]        area_reg [4];
    logic signed [39:0]        t_reg [4];
    logic signed [43:0]        wsum_reg;
    logic signed [NUM_W-1:0]   num_reg;
    logic signed [23:0]        ow_reg;
    logic                      neg_reg;
    logic        [MAG_W-1:0]   quo_reg;
    logic        [22:0]        rem_reg;
    logic        [5:0]         cnt_reg;
    logic signed [65:0]        prod_reg;
    logic                      m_valid_reg;
    wbis_out_t                 out_reg;

    logic        [16:0]        fx, fy, nfx, nfy;
    logic signed [32:0]        op_a, op_b;
    logic                      step_last, out_free;
    logic signed [56:0]        wv_sum;
    logic signed [43:0]        ws_rnd;
    logic signed [23:0]        ow_calc;
    logic signed [NUM_W-1:0]   prod_ext, num_abs;
    logic        [23:0]        rem_sh;
    logic                      ge;
    logic signed [31:0]        val_calc;
    logic        [33:0]        area_sum;

    assign fx  = (frac_x > 17'(ONE_Q16)) ? 17'(ONE_Q16) : frac_x;
    assign fy  = (frac_y > 17'(ONE_Q16)) ? 17'(ONE_Q16) : frac_y;
    assign nfx = 17'(ONE_Q16) - fx;
    assign nfy = 17'(ONE_Q16) - fy;

    assign step_last = half_reg && (k_reg == 2'd3);
    assign out_free  = !m_valid_reg || m_ready;

    // shared multiplier operands
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            B_AREA: begin
                op_a = {16'd0, k_reg[0] ? fx : nfx};
                op_b = {16'd0, k_reg[1] ? fy : nfy};
            end
            B_WV: begin
                op_a = 33'(signed'(job_reg.wt[k_reg]));
                op_b = 33'(signed'(job_reg.val[k_reg]));
            end
            B_AW: begin
                op_a = {16'd0, area_reg[k_reg]};
                op_b = 33'(signed'(job_reg.wt[k_reg]));
            end
            B_ATL: begin
                op_a = {16'd0, area_reg[k_reg]};
                op_b = {13'd0, t_reg[k_reg][19:0]};
            end
            B_ATH: begin
                op_a = {16'd0, area_reg[k_reg]};
                op_b = 33'(signed'(t_reg[k_reg][39:20]));
            end
            default: ;
        endcase
    end

    // rounding, saturation and divide step
    always_comb begin
        area_sum = prod_reg[33:0] + 34'd32768;
        wv_sum   = prod_reg[55:0] + 57'sd32768;
        prod_ext = prod_reg[NUM_W-1:0];
        ws_rnd   = (wsum_reg + 44'sd32768) >>> 16;
        if (ws_rnd > 44'sd8388607) begin
            ow_calc = 24'sh7FFFFF;
        end else if (ws_rnd < -44'sd8388608) begin
            ow_calc = 24'sh800000;
        end else begin
            ow_calc = ws_rnd[23:0];
        end
        num_abs = num_reg[NUM_W-1] ? -num_reg : num_reg;
        rem_sh  = {rem_reg, quo_reg[MAG_W-1]};
        ge      = rem_sh >= {1'b0, ow_reg[22:0]};
        if (ow_reg <= 24'sd0) begin
            val_calc = '0;
        end else if (!neg_reg) begin
            val_calc = (quo_reg > MAG_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : quo_reg[31:0];
        end else begin
            val_calc = (quo_reg > MAG_W'(33'h8000_0000)) ? 32'sh8000_0000
                                                          : -quo_reg[31:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:  if (!q_stat.empty) state_next = B_AREA;
            B_AREA:  if (step_last) state_next = B_WV;
            B_WV:    if (step_last) state_next = B_AW;
            B_AW:    if (step_last) state_next = B_ATL;
            B_ATL:   if (step_last) state_next = B_ATH;
            B_ATH:   if (step_last) state_next = B_FIN;
            B_FIN:   state_next = (ow_calc > 24'sd0) ? B_DIV : B_OUT;
            B_DIV:   if (cnt_reg == '0) state_next = B_OUT;
            B_OUT:   if (out_free) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        q_pop = 1'b0;
        case (state_reg)
            B_IDLE:  q_pop = !q_stat.empty;
            default: ;
        endcase
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        case (state_reg)
            B_IDLE: begin
                job_reg  <= head;
                k_reg    <= '0;
                half_reg <= 1'b0;
                wsum_reg <= '0;
                num_reg  <= '0;
            end
            B_AREA, B_WV, B_AW, B_ATL, B_ATH: begin
                half_reg <= !half_reg;
                if (half_reg) begin
                    k_reg <= k_reg + 2'd1;
                    case (state_reg)
                        B_AREA:  area_reg[k_reg] <= area_sum[32:16];
                        B_WV:    t_reg[k_reg]    <= wv_sum[55:16];
                        B_AW:    wsum_reg        <= wsum_reg + prod_reg[43:0];
                        B_ATL:   num_reg         <= num_reg + prod_ext;
                        default: num_reg         <= num_reg + (prod_ext <<< 20);
                    endcase
                end
            end
            B_FIN: begin
                ow_reg  <= ow_calc;
                neg_reg <= num_reg[NUM_W-1];
                quo_reg <= num_abs[MAG_W-1:0];
                rem_reg <= '0;
                cnt_reg <= 6'(MAG_W - 1);
            end
            B_DIV: begin
                rem_reg <= ge ? 23'(rem_sh - {1'b0, ow_reg[22:0]}) : rem_sh[22:0];
                quo_reg <= {quo_reg[MAG_W-2:0], ge};
                cnt_reg <= cnt_reg - 6'd1;
            end
            B_OUT: begin
                if (out_free) begin
                    out_reg.out_value     <= val_calc;
                    out_reg.out_weight    <= ow_reg;
                    out_reg.out_col       <= job_reg.col;
                    out_reg.out_row       <= job_reg.row;
                    out_reg.last_of_frame <= job_reg.last;
                end
            end
            default: ;
        endcase
    end

endmodule

@@ src/weighted_bilinear_image_shift.sv @@
// ----------------------------------------------------------------------------
// weighted_bilinear_image_shift
// sub-pixel shift of a weighted image by area-weighted bilinear interpolation
// ----------------------------------------------------------------------------
// Pixels with weights come in raster order, one request per pixel. The front
// takes a pixel, then reads and writes the row store, then hands off, and takes
// no new pixel until the hand-off is done; it queues one job per 2x2
// neighbourhood; no result comes for row 0 or column 0. The back works a job
// with multiplies on one shared 33x33 multiplier, then, only when the output
// weight is positive, a one-bit-per-cycle divider, then bookkeeping, so the
// back's multiplier and divider set the sustained rate. A two-entry queue lets
// the front run ahead, and the result register lets the back finish the next
// job while a result waits. Configuration must be written while the block is
// idle; the block does not enforce it. The row store holds MAX_WIDTH pixels.
// ----------------------------------------------------------------------------
module weighted_bilinear_image_shift import wbis_pkg::*; #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // pixel requests
    input  logic        s_valid,
    output logic        s_ready,
    input  wbis_in_t    s_payload,
    // result requests
    output logic        m_valid,
    input  logic        m_ready,
    output wbis_out_t   m_payload,
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    // configuration registers
    logic [12:0] image_width_reg;
    logic [12:0] image_height_reg;
    logic [16:0] frac_x_reg;
    logic [16:0] frac_y_reg;
    logic [10:0] offset_x_reg;
    logic [10:0] offset_y_reg;

    // queue between front and back
    logic        q_push, q_pop;
    wbis_job_t   q_data, q_head;
    wbis_qstat_t q_stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= 13'd4096;
            image_height_reg <= 13'd4096;
            frac_x_reg       <= 17'(ONE_Q16);
            frac_y_reg       <= 17'(ONE_Q16);
            offset_x_reg     <= 11'd1;
            offset_y_reg     <= 11'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[12:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[12:0];
                REG_FRAC_X:       frac_x_reg       <= cfg_data;
                REG_FRAC_Y:       frac_y_reg       <= cfg_data;
                REG_OFFSET_X:     offset_x_reg     <= cfg_data[10:0];
                REG_OFFSET_Y:     offset_y_reg     <= cfg_data[10:0];
                default:          ;  // unused indexes are ignored
            endcase
        end
    end

    // front: counters, row store, neighbour registers
    wbis_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_payload    (s_payload),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .offset_x     (offset_x_reg),
        .offset_y     (offset_y_reg),
        .q_stat       (q_stat),
        .q_push       (q_push),
        .q_data       (q_data)
    );

    wbis_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    // back: arithmetic and result register
    wbis_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .frac_x    (frac_x_reg),
        .frac_y    (frac_y_reg),
        .head      (q_head),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

@@ src/wbis_checker.sv @@
// ----------------------------------------------------------------------------
// wbis_checker
// port-level checks of the weighted bilinear image shift
// ----------------------------------------------------------------------------
`include "weighted_bilinear_image_shift_defines.svh"

module wbis_checker import wbis_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input wbis_out_t   m_payload
);

    `WBIS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid, "result dropped while stalled")
    `WBIS_ASSERT_NEXT(a_out_stable, m_valid && !m_ready, $stable(m_payload), "result changed while stalled")
    `WBIS_ASSERT_NEXT(a_one_pixel, s_valid && s_ready, !s_ready, "front took two pixels back to back")
    `WBIS_ASSERT_NOW(a_zero_value, m_valid && (m_payload.out_weight <= 24'sd0), m_payload.out_value == 32'sd0, "nonzero value with non-positive weight")

endmodule

bind weighted_bilinear_image_shift wbis_checker u_wbis_checker (.*);

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// drives pixel requests through the weighted bilinear image shift and checks
// every result against a built-in predictor of the interpolation
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb import wbis_pkg::*; ();

    localparam int MAX_W       = 4096;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN       = 400;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    wbis_in_t    s_payload;
    logic        m_valid;
    logic        m_ready;
    wbis_out_t   m_payload;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_data;

    weighted_bilinear_image_shift #(.MAX_WIDTH(MAX_W)) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // pending pixel requests and predicted results
    wbis_in_t  pixel_queue[$];
    wbis_out_t result_queue[$];
    int        failures;
    int        cycle_count;
    bit        pressure_off;     // long stretch with no idling on either side
    logic      s_ready_seen;     // request accepted at the last rising edge

    // predictor copy of configuration and state
    logic [12:0] p_width, p_height;
    logic [16:0] p_frac_x, p_frac_y;
    logic [10:0] p_offset_x, p_offset_y;
    logic signed [31:0] p_row_val [MAX_W];
    logic signed [23:0] p_row_wt  [MAX_W];
    logic signed [31:0] p_left_val, p_upleft_val;
    logic signed [23:0] p_left_wt, p_upleft_wt;
    int unsigned p_col, p_row;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    // timeout guard
    always @(posedge aclk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // floor((x + 2^15) / 2^16)
    function automatic longint round_q16(longint x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clip(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    // advance the predictor by one accepted pixel
    function automatic void predict_pixel(wbis_in_t px);
        int unsigned wd, ht, ci;
        longint fx, fy, ow, ov, wsum, num;
        longint area[4], wts[4], vals[4];
        logic signed [31:0] up_v;
        logic signed [23:0] up_w;
        wbis_out_t res;
        wd = p_width < 2 ? 2 : (p_width > MAX_W ? MAX_W : p_width);
        ht = p_height < 2 ? 2 : (p_height > MAX_HEIGHT ? MAX_HEIGHT : p_height);
        if (px.start_of_frame) begin
            p_col = 0;
            p_row = 0;
        end
        ci = p_col < MAX_W ? p_col : MAX_W - 1;
        up_v = p_row_val[ci];
        up_w = p_row_wt[ci];
        if (p_row >= 1 && p_col >= 1) begin
            fx = p_frac_x > ONE_Q16 ? ONE_Q16 : p_frac_x;
            fy = p_frac_y > ONE_Q16 ? ONE_Q16 : p_frac_y;
            area[0] = ((ONE_Q16 - fx) * (ONE_Q16 - fy) + 32768) >> 16;
            area[1] = (fx * (ONE_Q16 - fy) + 32768) >> 16;
            area[2] = ((ONE_Q16 - fx) * fy + 32768) >> 16;
            area[3] = (fx * fy + 32768) >> 16;
            wts[0] = p_upleft_wt; vals[0] = p_upleft_val;
            wts[1] = up_w;        vals[1] = up_v;
            wts[2] = p_left_wt;   vals[2] = p_left_val;
            wts[3] = px.pixel_weight; vals[3] = px.pixel_value;
            wsum = 0;
            num  = 0;
            for (int k = 0; k < 4; k++) begin
                wsum += area[k] * wts[k];
                num  += area[k] * round_q16(wts[k] * vals[k]);
            end
            ow = clip(round_q16(wsum), -64'sd8388608, 64'sd8388607);
            ov = 0;
            if (ow > 0) ov = clip(num / ow, -64'sd2147483648, 64'sd2147483647);
            res.out_value     = ov[31:0];
            res.out_weight    = ow[23:0];
            res.out_col       = 13'(p_col - 1 + p_offset_x);
            res.out_row       = 13'(p_row - 1 + p_offset_y);
            res.last_of_frame = (p_row >= ht - 1 && p_col >= wd - 1);
            result_queue.push_back(res);
        end
        p_upleft_val = up_v;
        p_upleft_wt  = up_w;
        p_row_val[ci] = px.pixel_value;
        p_row_wt[ci]  = px.pixel_weight;
        p_left_val = px.pixel_value;
        p_left_wt  = px.pixel_weight;
        if (p_col >= wd - 1) begin
            p_col = 0;
            p_row = (p_row >= ht - 1) ? 0 : p_row + 1;
        end else begin
            p_col = p_col + 1;
        end
    endfunction

    // driver: inputs change on the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready_seen) begin
            if (pixel_queue.size() > 0 && (pressure_off || $urandom_range(99) >= 30)) begin
                s_payload <= pixel_queue.pop_front();
                s_valid   <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        if (aresetn) m_ready <= pressure_off || $urandom_range(99) >= 30;
    end

    // accepted-request flag sampled at the rising edge
    always @(posedge aclk) begin
        s_ready_seen <= 1'b0;
        if (aresetn && s_valid && s_ready) begin
            s_ready_seen <= 1'b1;
            predict_pixel(s_payload);
        end
    end

    // monitor: compare each result with the oldest prediction
    always @(posedge aclk) begin
        wbis_out_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (result_queue.size() == 0) begin
                $error("unexpected result col %0d row %0d", m_payload.out_col,
                       m_payload.out_row);
                failures++;
            end else begin
                exp_res = result_queue.pop_front();
                if (m_payload.out_value !== exp_res.out_value) begin
                    $error("out_value expected %0d got %0d", exp_res.out_value,
                           m_payload.out_value);
                    failures++;
                end
                if (m_payload.out_weight !== exp_res.out_weight) begin
                    $error("out_weight expected %0d got %0d", exp_res.out_weight,
                           m_payload.out_weight);
                    failures++;
                end
                if (m_payload.out_col !== exp_res.out_col) begin
                    $error("out_col expected %0d got %0d", exp_res.out_col,
                           m_payload.out_col);
                    failures++;
                end
                if (m_payload.out_row !== exp_res.out_row) begin
                    $error("out_row expected %0d got %0d", exp_res.out_row,
                           m_payload.out_row);
                    failures++;
                end
                if (m_payload.last_of_frame !== exp_res.last_of_frame) begin
                    $error("last_of_frame expected %0d got %0d",
                           exp_res.last_of_frame, m_payload.last_of_frame);
                    failures++;
                end
            end
        end
    end

    // register write on one rising edge, predictor updated alongside
    task automatic write_reg(logic [2:0] idx, logic [16:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:  p_width    = data[12:0];
            REG_IMAGE_HEIGHT: p_height   = data[12:0];
            REG_FRAC_X:       p_frac_x   = data;
            REG_FRAC_Y:       p_frac_y   = data;
            REG_OFFSET_X:     p_offset_x = data[10:0];
            default:          p_offset_y = data[10:0];
        endcase
    endtask

    // wait for the block to drain, then a margin for in-flight work
    task automatic wait_idle();
        while (pixel_queue.size() > 0 || s_valid || result_queue.size() > 0)
            @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    function automatic wbis_in_t rand_pixel(bit sof, int style);
        wbis_in_t px;
        px.start_of_frame = sof;
        case (style)
            0: begin   // full random
                px.pixel_value  = $urandom;
                px.pixel_weight = 24'($urandom);
            end
            1: begin   // values around zero, non-negative moderate weights
                px.pixel_value  = $urandom_range(32'h0040_0000) - 32'h0020_0000;
                px.pixel_weight = 24'($urandom_range(24'h02_0000));
            end
            default: begin   // field extremes
                px.pixel_value  = $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
                px.pixel_weight = $urandom_range(1) ? 24'sh7f_ffff : 24'sh80_0000;
            end
        endcase
        return px;
    endfunction

    // one whole frame; only the first pixel carries start of frame
    task automatic queue_frame(int wd, int ht);
        for (int r = 0; r < ht; r++)
            for (int c = 0; c < wd; c++)
                pixel_queue.push_back(rand_pixel(r == 0 && c == 0,
                                                 $urandom_range(9) < 6 ? 1 :
                                                 ($urandom_range(3) == 0 ? 2 : 0)));
    endtask

    initial begin
        int sent;
        int wd, ht;
        wbis_in_t px;
        failures     = 0;
        cycle_count  = 0;
        pressure_off = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_payload    = '0;
        m_ready      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = REG_IMAGE_WIDTH;
        cfg_data     = '0;
        p_width = 4096; p_height = 4096;
        p_frac_x = ONE_Q16; p_frac_y = ONE_Q16;
        p_offset_x = 1; p_offset_y = 1;
        p_left_val = 0; p_left_wt = 0; p_upleft_val = 0; p_upleft_wt = 0;
        p_col = 0; p_row = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: small frame, extreme fields, zero-weight and saturation cases
        write_reg(REG_IMAGE_WIDTH, 17'd3);
        write_reg(REG_IMAGE_HEIGHT, 17'd3);
        write_reg(REG_FRAC_X, 17'd0);
        write_reg(REG_FRAC_Y, 17'd65536);
        write_reg(REG_OFFSET_X, 17'd2047);
        write_reg(REG_OFFSET_Y, 17'd0);
        for (int k = 0; k < 9; k++) begin
            px.start_of_frame = (k == 0);
            px.pixel_value  = k[0] ? 32'sh7fff_ffff : 32'sh8000_0000;
            px.pixel_weight = (k % 3 == 0) ? 24'sh7f_ffff :
                              (k % 3 == 1) ? 24'sh80_0000 : 24'sh00_0000;
            pixel_queue.push_back(px);
        end
        wait_idle();

        // size below range clamps to 2; fractions above one count as one
        write_reg(REG_IMAGE_WIDTH, 17'd0);
        write_reg(REG_IMAGE_HEIGHT, 17'd1);
        write_reg(REG_FRAC_X, 17'h1ffff);
        write_reg(REG_FRAC_Y, 17'd32768);
        write_reg(REG_OFFSET_Y, 17'd2047);
        queue_frame(2, 2);
        // frame wrap continues without start of frame
        for (int k = 0; k < 4; k++) pixel_queue.push_back(rand_pixel(0, 2));
        wait_idle();

        // width changed mid-frame, at the start of a row
        write_reg(REG_IMAGE_WIDTH, 17'd5);
        write_reg(REG_IMAGE_HEIGHT, 17'd4);
        queue_frame(5, 2);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 17'd3);
        for (int k = 0; k < 3; k++) pixel_queue.push_back(rand_pixel(0, 1));
        wait_idle();

        // random phases over several settings
        sent = 0;
        while (sent < 1150) begin
            wd = $urandom_range(9) == 0 ? $urandom_range(40, 64) : $urandom_range(2, 8);
            ht = $urandom_range(2, 6);
            if ($urandom_range(7) == 0) wd = $urandom_range(8191, 4097);
            write_reg(REG_IMAGE_WIDTH, wd > 4096 ? 17'(wd) : 17'(wd));
            if (wd > 4096) wd = 4096;
            if (wd == 4096) ht = 2;
            write_reg(REG_IMAGE_HEIGHT, $urandom_range(3) == 0 ?
                      17'($urandom_range(8191, 4096)) : 17'(ht));
            if (p_height < 4096 || p_height > 8191) ; // no-op guard
            ht = p_height >= 4096 ? 2 : ht;
            if (p_height >= 4096) begin
                // tall setting: feed only two rows, the block keeps counting
                wd = wd > 64 ? 4096 : wd;
            end
            write_reg(REG_FRAC_X, $urandom_range(4) == 0 ? 17'h1ffff :
                      17'($urandom_range(65536)));
            write_reg(REG_FRAC_Y, 17'($urandom_range(65536)));
            write_reg(REG_OFFSET_X, 17'($urandom_range(2047)));
            write_reg(REG_OFFSET_Y, 17'($urandom_range(2047)));
            pressure_off = (sent > 400 && sent < 600);
            if (wd == 4096) begin
                // wide setting: part of the first row only, no neighbourhoods
                for (int k = 0; k < 32; k++)
                    pixel_queue.push_back(rand_pixel(k == 0, 0));
                sent += 32;
            end else begin
                for (int f = 0; f < $urandom_range(1, 3); f++) begin
                    queue_frame(wd, ht);
                    // occasional truncated frame restarted by start of frame
                    if ($urandom_range(5) == 0)
                        for (int k = 0; k < $urandom_range(1, wd + 1); k++)
                            pixel_queue.push_back(rand_pixel(k == 0, 0));
                    sent += wd * ht;
                end
            end
            wait_idle();
        end

        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
